// ===== rtl/bba_pkg.sv =====
// Package for the bitmap block allocator: field widths, opcodes, map constants,
// sequencer state type and the lowest-clear-bit helper. No dependencies.
package bba_pkg;

	localparam int NUM_BLOCKS_DEF = 512;
	localparam int OP_W           = 2;
	localparam int BLK_W          = 9;
	localparam int BYTE_W         = 8;

	localparam logic [OP_W-1:0] OP_FORMAT  = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

	localparam logic [BYTE_W-1:0] BOOT_MASK = 8'h03;
	localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FMT,
		ST_REL,
		ST_SCAN,
		ST_RESP
	} bba_state_t;

	// position of the lowest clear bit; only meaningful when the byte is not full
	function automatic logic [2:0] lowest_clear(input logic [BYTE_W-1:0] b);
		logic [2:0] pos;
		pos = 3'd0;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			if (!b[i]) begin
				pos = 3'(i);
			end
		end
		return pos;
	endfunction

endpackage

// ===== rtl/bba_if.sv =====
// Valid/ready channel interfaces for the block allocator's request and response.
// Depends on bba_pkg for the field widths.
interface bba_req_if;
	import bba_pkg::*;
	logic            valid;
	logic            ready;
	logic [OP_W-1:0]  op;
	logic [BLK_W-1:0] block_number;
	modport source (output valid, op, block_number, input ready);
	modport sink   (input valid, op, block_number, output ready);
endinterface

interface bba_rsp_if;
	import bba_pkg::*;
	logic             valid;
	logic             ready;
	logic [BLK_W-1:0] allocated_block;
	logic             status;
	modport source (output valid, allocated_block, status, input ready);
	modport sink   (input valid, allocated_block, status, output ready);
endinterface

// ===== rtl/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
// Bitmap block allocator top level: sequencer, map RAM and response register.
// Depends on bba_pkg, bba_req_if / bba_rsp_if and bba_ram.
//
// Usage:
//   req carries op (format, allocate, release) and block_number; rsp returns
//   allocated_block and status, one response per request, in order.
//   One request is worked at a time; req.ready is high only while idle.
//   The free map sits in a RAM of NUM_BLOCKS/8 bytes (rounded up), one bit
//   per block, read one byte per cycle through its single read port.
//   Steps per request: format and an in-range release read a map byte and
//   write it back before the response (format only if both boot bits are
//   clear); an unused opcode or a release out of range goes straight to the
//   response state; an allocate scans bytes from 0 to a clear bit or the end.
//   The byte scan sets the rate.
//   After reset a clearing pass writes zeros to every map byte (64 at the
//   default size), with req.ready low.
//   A finished response waits in an output register; the next request is
//   still accepted, and its response waits in the sequencer until rsp
//   frees up, so a stalled receiver eventually holds off req.
module bitmap_block_allocator #(
	parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bba_req_if.sink     req,
	bba_rsp_if.source   rsp
);
	import bba_pkg::*;

	localparam int MAP_BYTES = (NUM_BLOCKS + BYTE_W - 1) / BYTE_W;
	localparam int ADDR_W    = $clog2(MAP_BYTES);
	localparam int IDX_W     = ADDR_W + 3;
	localparam int EXT_W     = IDX_W + BLK_W;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);
	localparam logic [IDX_W:0]    NUM_BLK_C = (IDX_W + 1)'(NUM_BLOCKS);

	bba_state_t state_q, state_d;
	logic [ADDR_W-1:0] chk_q, chk_d;          // byte under work; also clear counter
	logic [BLK_W-1:0]  blk_q, blk_d;           // release target
	logic [BLK_W-1:0]  res_blk_q, res_blk_d;   // pending response
	logic              res_st_q, res_st_d;
	logic              ovalid_q;
	logic [BLK_W-1:0]  oblk_q;
	logic              ost_q;

	logic              ram_we;
	logic [BYTE_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;
	logic              out_load;

	// request address helpers
	logic [ADDR_W+BLK_W-1:0] req_byte_ext;
	logic                    req_in_range;
	logic [2:0]              clr_pos;
	logic [IDX_W-1:0]        scan_idx;
	logic [EXT_W-1:0]        scan_idx_ext;

	assign req_byte_ext = (ADDR_W + BLK_W)'(req.block_number[BLK_W-1:3]);
	assign req_in_range = 32'(req.block_number) < 32'(NUM_BLOCKS);
	assign clr_pos      = lowest_clear(ram_rdata);
	assign scan_idx     = {chk_q, clr_pos};
	assign scan_idx_ext = EXT_W'(scan_idx);

	bba_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAP_BYTES)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (chk_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			chk_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_q   <= chk_d;
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		blk_q     <= blk_d;
		res_blk_q <= res_blk_d;
		res_st_q  <= res_st_d;
		if (out_load) begin
			oblk_q <= res_blk_q;
			ost_q  <= res_st_q;
		end
	end

	always_comb begin
		state_d   = state_q;
		chk_d     = chk_q;
		blk_d     = blk_q;
		res_blk_d = res_blk_q;
		res_st_d  = res_st_q;
		ram_we    = 1'b0;
		ram_wdata = '0;
		ram_raddr = chk_q + 1'b1;   // scan prefetch of the next byte
		req.ready = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				chk_d  = chk_q + 1'b1;
				if (chk_q == LAST_ADDR) begin
					chk_d   = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				ram_raddr = '0;
				res_blk_d = '0;
				res_st_d  = STATUS_OK;
				if (req.valid) begin
					blk_d = req.block_number;
					chk_d = '0;
					case (req.op)
						OP_FORMAT: state_d = ST_FMT;
						OP_ALLOC:  state_d = ST_SCAN;
						OP_RELEASE: begin
							ram_raddr = req_byte_ext[ADDR_W-1:0];
							chk_d     = req_byte_ext[ADDR_W-1:0];
							state_d   = req_in_range ? ST_REL : ST_RESP;
						end
						default: state_d = ST_RESP;   // unused opcode: no map change
					endcase
				end
			end
			ST_FMT: begin
				// mark the two boot blocks only when both are free
				ram_we    = (ram_rdata & BOOT_MASK) == '0;
				ram_wdata = ram_rdata | BOOT_MASK;
				state_d   = ST_RESP;
			end
			ST_REL: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata & ~(8'h01 << blk_q[2:0]);
				state_d   = ST_RESP;
			end
			ST_SCAN: begin
				if (ram_rdata != FULL_BYTE) begin
					state_d = ST_RESP;
					if ({1'b0, scan_idx} < NUM_BLK_C) begin
						ram_we    = 1'b1;
						ram_wdata = ram_rdata | (8'h01 << clr_pos);
						res_blk_d = scan_idx_ext[BLK_W-1:0];
					end else begin
						res_st_d = STATUS_FULL;   // free bit lies past the last block
					end
				end else if (chk_q == LAST_ADDR) begin
					res_st_d = STATUS_FULL;
					state_d  = ST_RESP;
				end else begin
					chk_d = chk_q + 1'b1;
				end
			end
			ST_RESP: begin
				if (!ovalid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign rsp.valid           = ovalid_q;
	assign rsp.allocated_block = oblk_q;
	assign rsp.status          = ost_q;

`ifndef SYNTHESIS
	// one request at a time: after a transfer the sequencer is busy
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while busy");

	// a full status never carries a block index
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status) |-> (rsp.allocated_block == '0))
		else $error("full status with nonzero block");

	// the map is never written while waiting for a request
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ram_we)
		else $error("map write while idle");

	// a response is loaded only into a free or draining output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && ovalid_q) |-> rsp.ready)
		else $error("response overwritten");
`endif

endmodule
